// File: sv/l2tpds_pkg.sv
`timescale 1ns / 1ps

package l2tpds_pkg;

	typedef enum logic [3:0] {
		PH_FLAGS   = 4'd0,
		PH_VER     = 4'd1,
		PH_LEN_HI  = 4'd2,
		PH_LEN_LO  = 4'd3,
		PH_TUN_HI  = 4'd4,
		PH_TUN_LO  = 4'd5,
		PH_SES_HI  = 4'd6,
		PH_SES_LO  = 4'd7,
		PH_NSNR    = 4'd8,
		PH_OFF_HI  = 4'd9,
		PH_OFF_LO  = 4'd10,
		PH_PAD     = 4'd11,
		PH_PAYLOAD = 4'd12,
		PH_DROP    = 4'd13
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PAYLOAD     = 3'd0,
		KIND_BAD_VERSION = 3'd1,
		KIND_CONTROL     = 3'd2,
		KIND_TRUNCATED   = 3'd3,
		KIND_EMPTY       = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		VERDICT_KEEP        = 2'd0,
		VERDICT_BAD_VERSION = 2'd1,
		VERDICT_CONTROL     = 2'd2
	} verdict_t;

	// header flag positions inside the saved flag vector
	localparam int unsigned FL_L = 2;
	localparam int unsigned FL_S = 1;
	localparam int unsigned FL_O = 0;

	localparam logic [3:0]  L2TP_VERSION = 4'd2;
	localparam logic [15:0] NSNR_BYTES   = 16'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  payload_byte;
		logic [15:0] tunnel;
		logic [15:0] session;
		logic        end_of_packet;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  flags;
		logic [15:0] tunnel;
		logic [15:0] session;
		logic [15:0] skip;
		logic [7:0]  off_hi;
		verdict_t    verdict;
	} parse_state_t;

endpackage

// File: sv/l2tpds_parse.sv
`timescale 1ns / 1ps

module l2tpds_parse (
	input  l2tpds_pkg::parse_state_t cur,
	input  l2tpds_pkg::item_t        item,
	output l2tpds_pkg::parse_state_t nxt,
	output logic                     res_present,
	output l2tpds_pkg::result_t      res
);

	logic [7:0]  b;
	logic        forwarded;
	logic [15:0] skip_dec;
	logic        drop_by_version;

	assign b        = item.data_byte;
	assign skip_dec = (cur.skip != 16'd0) ? (cur.skip - 16'd1) : cur.skip;
	assign drop_by_version = (b[3:0] != l2tpds_pkg::L2TP_VERSION);

	always_comb begin
		nxt       = cur;
		forwarded = 1'b0;
		case (cur.phase)
			l2tpds_pkg::PH_FLAGS: begin
				nxt.tunnel  = 16'd0;
				nxt.session = 16'd0;
				nxt.skip    = 16'd0;
				nxt.off_hi  = 8'd0;
				nxt.flags   = {b[6], b[3], b[1]};
				nxt.verdict = b[7] ? l2tpds_pkg::VERDICT_CONTROL : l2tpds_pkg::VERDICT_KEEP;
				nxt.phase   = l2tpds_pkg::PH_VER;
			end
			l2tpds_pkg::PH_VER: begin
				// bad version wins over control
				if (drop_by_version) begin
					nxt.verdict = l2tpds_pkg::VERDICT_BAD_VERSION;
					nxt.phase   = l2tpds_pkg::PH_DROP;
				end else if (cur.verdict != l2tpds_pkg::VERDICT_KEEP) begin
					nxt.phase = l2tpds_pkg::PH_DROP;
				end else if (cur.flags[l2tpds_pkg::FL_L]) begin
					nxt.phase = l2tpds_pkg::PH_LEN_HI;
				end else begin
					nxt.phase = l2tpds_pkg::PH_TUN_HI;
				end
			end
			l2tpds_pkg::PH_LEN_HI: nxt.phase = l2tpds_pkg::PH_LEN_LO;
			l2tpds_pkg::PH_LEN_LO: nxt.phase = l2tpds_pkg::PH_TUN_HI;
			l2tpds_pkg::PH_TUN_HI: begin
				nxt.tunnel = {b, 8'd0};
				nxt.phase  = l2tpds_pkg::PH_TUN_LO;
			end
			l2tpds_pkg::PH_TUN_LO: begin
				nxt.tunnel = {cur.tunnel[15:8], b};
				nxt.phase  = l2tpds_pkg::PH_SES_HI;
			end
			l2tpds_pkg::PH_SES_HI: begin
				nxt.session = {b, 8'd0};
				nxt.phase   = l2tpds_pkg::PH_SES_LO;
			end
			l2tpds_pkg::PH_SES_LO: begin
				nxt.session = {cur.session[15:8], b};
				if (cur.flags[l2tpds_pkg::FL_S]) begin
					nxt.skip  = l2tpds_pkg::NSNR_BYTES;
					nxt.phase = l2tpds_pkg::PH_NSNR;
				end else if (cur.flags[l2tpds_pkg::FL_O]) begin
					nxt.phase = l2tpds_pkg::PH_OFF_HI;
				end else begin
					nxt.phase = l2tpds_pkg::PH_PAYLOAD;
				end
			end
			l2tpds_pkg::PH_NSNR: begin
				nxt.skip = skip_dec;
				if (skip_dec == 16'd0) begin
					nxt.phase = cur.flags[l2tpds_pkg::FL_O] ? l2tpds_pkg::PH_OFF_HI
						: l2tpds_pkg::PH_PAYLOAD;
				end
			end
			l2tpds_pkg::PH_OFF_HI: begin
				nxt.off_hi = b;
				nxt.phase  = l2tpds_pkg::PH_OFF_LO;
			end
			l2tpds_pkg::PH_OFF_LO: begin
				nxt.skip  = {cur.off_hi, b};
				nxt.phase = ({cur.off_hi, b} == 16'd0) ? l2tpds_pkg::PH_PAYLOAD
					: l2tpds_pkg::PH_PAD;
			end
			l2tpds_pkg::PH_PAD: begin
				nxt.skip = skip_dec;
				if (skip_dec == 16'd0)
					nxt.phase = l2tpds_pkg::PH_PAYLOAD;
			end
			l2tpds_pkg::PH_PAYLOAD: forwarded = 1'b1;
			l2tpds_pkg::PH_DROP: ;
			default: nxt.phase = l2tpds_pkg::PH_DROP;
		endcase

		// status is judged on the phase reached after this byte
		res = '0;
		res.end_of_packet = item.last_byte;
		if (forwarded) begin
			res.kind         = l2tpds_pkg::KIND_PAYLOAD;
			res.payload_byte = b;
			res.tunnel       = nxt.tunnel;
			res.session      = nxt.session;
		end else if (nxt.phase == l2tpds_pkg::PH_PAYLOAD) begin
			res.kind    = l2tpds_pkg::KIND_EMPTY;
			res.tunnel  = nxt.tunnel;
			res.session = nxt.session;
		end else if (nxt.phase == l2tpds_pkg::PH_DROP
				&& nxt.verdict != l2tpds_pkg::VERDICT_KEEP) begin
			res.kind = {1'b0, nxt.verdict};
		end else begin
			res.kind = l2tpds_pkg::KIND_TRUNCATED;
		end
		res_present = forwarded | item.last_byte;

		if (item.last_byte) begin
			nxt.phase   = l2tpds_pkg::PH_FLAGS;
			nxt.verdict = l2tpds_pkg::VERDICT_KEEP;
			nxt.skip    = 16'd0;
		end
	end

endmodule

// File: sv/l2tp_data_header_stripper_core.sv
`timescale 1ns / 1ps
// datapath: each byte passes through the input register, then parse logic into the
// result register
// throughput: one byte per cycle; a stalled result register stalls the input register
// reset: parser returns to the first header byte, header fields and flags clear,
// both registers empty

module l2tp_data_header_stripper_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  l2tpds_pkg::item_t   item,
	output logic                res_valid,
	input  logic                res_stall,
	output l2tpds_pkg::result_t res
);

	logic                     valid_s1;
	l2tpds_pkg::item_t        item_s1;
	l2tpds_pkg::parse_state_t state_q;
	l2tpds_pkg::parse_state_t state_nxt;
	logic                     step_res;
	l2tpds_pkg::result_t      step_out;
	logic                     out_free;
	logic                     adv;
	logic                     res_valid_q;
	l2tpds_pkg::result_t      res_q;

	assign out_free   = !res_valid_q || !res_stall;
	assign adv        = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	l2tpds_parse u_parse (
		.cur         (state_q),
		.item        (item_s1),
		.nxt         (state_nxt),
		.res_present (step_res),
		.res         (step_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= l2tpds_pkg::PH_FLAGS;
			state_q.flags   <= 3'd0;
			state_q.tunnel  <= 16'd0;
			state_q.session <= 16'd0;
			state_q.skip    <= 16'd0;
			state_q.off_hi  <= 8'd0;
			state_q.verdict <= l2tpds_pkg::VERDICT_KEEP;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= adv && step_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step_res)
			res_q <= step_out;
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_last_resets_parser: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last_byte |=> state_q.phase == l2tpds_pkg::PH_FLAGS
			&& state_q.verdict == l2tpds_pkg::VERDICT_KEEP)
		else $error("parser not back at first header byte after packet end");

	a_drop_has_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == l2tpds_pkg::PH_DROP |-> state_q.verdict != l2tpds_pkg::VERDICT_KEEP)
		else $error("dropping packet without a verdict");

	a_status_ends_packet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind != l2tpds_pkg::KIND_PAYLOAD |-> res.end_of_packet
			&& res.payload_byte == 8'd0)
		else $error("status result not on packet end or carries data");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(valid_s1))
		else $error("result appeared without an item");

endmodule
